// File: rtl/core/swm_pkg.sv
// swm_pkg: shared types and constants for the sliding-window median filter.
// Used by swm_cell, swm_history and sliding_window_median_top. No dependencies.
package swm_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int SAMPLE_W   = 32;
  localparam int MED_W      = 33;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int POS_W      = $clog2(MAX_WINDOW);

  localparam logic [CNT_W-1:0] WS_RESET = CNT_W'(3);

  // one sorted slot; an invalid slot orders above every sample
  typedef struct packed {
    logic                       vld;
    logic signed [SAMPLE_W-1:0] val;
  } entry_t;

  function automatic logic entry_le(input entry_t e, input logic signed [SAMPLE_W-1:0] s);
    return e.vld && (e.val <= s);
  endfunction

  function automatic logic entry_ge(input entry_t e, input logic signed [SAMPLE_W-1:0] s);
    return !e.vld || (e.val >= s);
  endfunction

endpackage

// File: rtl/core/swm_cell.sv
// swm_cell: one slot of the sorted window; drops the retired sample and inserts
// the new one in the same update, from its own and its neighbors' contents. Uses swm_pkg.
module swm_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wipe,
  input  logic                            ld,
  input  logic                            clr,
  input  logic                            remove,
  input  logic                            head,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] new_val,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] old_val,
  input  swm_pkg::entry_t                 left,
  input  logic                            left_ge,
  input  swm_pkg::entry_t                 right,
  output swm_pkg::entry_t                 cur,
  output logic                            ge
);
  import swm_pkg::*;

  entry_t slot;
  entry_t slot_next;
  entry_t w_self;
  entry_t w_left;

  always_comb begin
    cur     = slot;
    cur.vld = slot.vld & ~clr;
  end

  // at or past the first copy of the retired sample
  assign ge = remove & entry_ge(cur, old_val);

  always_comb begin
    w_self = ge ? right : cur;
    w_left = left_ge ? cur : left;
    if (entry_le(w_self, new_val)) begin
      slot_next = w_self;
    end else if (head || entry_le(w_left, new_val)) begin
      slot_next.vld = 1'b1;
      slot_next.val = new_val;
    end else begin
      slot_next = w_left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || wipe) begin
      slot.vld <= 1'b0;
    end else if (ld) begin
      slot.vld <= slot_next.vld;
    end
    if (ld) begin
      slot.val <= slot_next.val;
    end
  end

endmodule

// File: rtl/core/swm_history.sv
// swm_history: arrival-order ring of samples, one write and one registered read
// port. Uses swm_pkg.
module swm_history (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [swm_pkg::POS_W-1:0]       wr_addr,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] wr_data,
  input  logic [swm_pkg::POS_W-1:0]       rd_addr,
  output logic signed [swm_pkg::SAMPLE_W-1:0] rd_data
);
  import swm_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/sliding_window_median_top.sv
// sliding_window_median_top: sliding-window median over a chain of sorted cells
// plus an arrival-order history ring. Uses swm_pkg, swm_cell, swm_history.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_stall    sample, restart
//   out       output     out_valid / out_stall  median_doubled
//   cfg       input      cfg_wr_en              cfg_wr_data (window_size)
//
// Each request: the cell chain updates at the accepting edge, and the median is
// then read from the middle cells, summed and registered once the output is free.
// in_stall is high while that sum is pending and stays high while the output
// register holds an untaken result.
// Reset (rst, synchronous) empties the window and sets window_size to 3; in_stall
// is held high while rst is asserted.
module sliding_window_median_top
  import swm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       restart,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [MED_W-1:0]    median_doubled,
  input  logic                       cfg_wr_en,
  input  logic [CNT_W-1:0]           cfg_wr_data
);

  logic [CNT_W-1:0] window_size;
  logic [CNT_W-1:0] fill;
  logic [POS_W-1:0] oldest;
  logic             calc;
  logic             emit;

  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] fill_eff;
  logic [POS_W-1:0] pos_eff;
  logic [POS_W-1:0] p;
  logic [CNT_W-1:0] p_inc;
  logic [CNT_W-1:0] fill_inc;
  logic             remove;
  logic             accept;
  logic             out_free;
  logic [POS_W-1:0] wr_addr;
  logic signed [SAMPLE_W-1:0] old_val;

  logic [POS_W-1:0] idx_hi;
  logic [POS_W-1:0] idx_lo;
  logic signed [MED_W-1:0] med_sum;

  entry_t cells [MAX_WINDOW+1];
  logic   ges   [MAX_WINDOW];
  entry_t edge_in;

  always_comb begin
    if (window_size == '0) begin
      n_eff = CNT_W'(1);
    end else if (window_size > CNT_W'(MAX_WINDOW)) begin
      n_eff = CNT_W'(MAX_WINDOW);
    end else begin
      n_eff = window_size;
    end
  end

  assign in_stall = calc | rst;
  assign accept   = in_valid & ~in_stall;
  assign out_free = ~out_valid | ~out_stall;

  assign fill_eff = restart ? '0 : fill;
  assign pos_eff  = restart ? '0 : oldest;
  assign remove   = fill_eff >= n_eff;
  assign p        = ({1'b0, pos_eff} < n_eff) ? pos_eff : '0;
  assign p_inc    = {1'b0, p} + CNT_W'(1);
  assign fill_inc = fill_eff + CNT_W'(1);
  assign wr_addr  = remove ? p : fill_eff[POS_W-1:0];

  swm_history u_history (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (wr_addr),
    .wr_data (sample),
    .rd_addr (oldest),
    .rd_data (old_val)
  );

  always_comb begin
    edge_in     = '0;
    edge_in.vld = 1'b0;
  end
  assign cells[MAX_WINDOW] = edge_in;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    entry_t left_e;
    logic   left_g;
    logic   is_head;
    if (i == 0) begin : g_head
      assign left_e  = edge_in;
      assign left_g  = 1'b0;
      assign is_head = 1'b1;
    end else begin : g_body
      assign left_e  = cells[i-1];
      assign left_g  = ges[i-1];
      assign is_head = 1'b0;
    end
    swm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .wipe    (cfg_wr_en),
      .ld      (accept),
      .clr     (accept & restart),
      .remove  (remove),
      .head    (is_head),
      .new_val (sample),
      .old_val (old_val),
      .left    (left_e),
      .left_ge (left_g),
      .right   (cells[i+1]),
      .cur     (cells[i]),
      .ge      (ges[i])
    );
  end

  // middle slots: equal for an odd window
  assign idx_hi   = n_eff[CNT_W-1:1];
  assign idx_lo   = n_eff[0] ? idx_hi : idx_hi - POS_W'(1);
  assign med_sum  = MED_W'(cells[{1'b0, idx_hi}].val) + MED_W'(cells[{1'b0, idx_lo}].val);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WS_RESET;
      fill        <= '0;
      oldest      <= '0;
      calc        <= 1'b0;
      emit        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_size <= cfg_wr_data;
        fill        <= '0;
        oldest      <= '0;
      end else if (accept) begin
        fill   <= remove ? fill_eff : fill_inc;
        oldest <= (remove && p_inc < n_eff) ? p_inc[POS_W-1:0] : '0;
        calc   <= 1'b1;
        emit   <= remove | (fill_inc >= n_eff);
      end
      if (calc && out_free) begin
        calc      <= 1'b0;
        out_valid <= emit;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (calc && out_free && emit) begin
      median_doubled <= med_sum;
    end
  end

endmodule

// File: tb/sv/tb_sliding_window_median_top.sv
`timescale 1ns / 100ps
// tb_sliding_window_median_top: self-checking bench for the sliding-window median filter.
// Directed and random sample streams against an in-bench sorted-window predictor.
// Depends on swm_pkg and sliding_window_median_top.
module tb_sliding_window_median_top;
  import swm_pkg::*;

  localparam int QUIET_LIMIT  = 500;
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_ITEMS = 1250;
  localparam int MAX_GAP      = 12;
  localparam int PRINT_CAP    = 30;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MED_W-1:0]    med_t;

  localparam sample_t S_MIN = sample_t'(32'h8000_0000);
  localparam sample_t S_MAX = sample_t'(32'h7fff_ffff);

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  sample_t          sample      = '0;
  logic             restart     = 1'b0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  med_t             median_doubled;
  logic             cfg_wr_en   = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;

  int   mismatches    = 0;
  bit   in_gaps_on    = 1'b1;
  bit   out_stalls_on = 1'b1;
  med_t medians_due[$];

  // predictor state
  logic [CNT_W-1:0] win_size_reg;
  sample_t          win_sorted[$];
  sample_t          win_hist[MAX_WINDOW];
  int               win_oldest;

  sliding_window_median_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sample         (sample),
    .restart        (restart),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .median_doubled (median_doubled),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int eff_window();
    if (win_size_reg == 0) return 1;
    if (win_size_reg > MAX_WINDOW) return MAX_WINDOW;
    return int'(win_size_reg);
  endfunction

  // update the window with one accepted request, queue the median once full
  function automatic void median_step(input sample_t s, input logic rs);
    int   n;
    int   p;
    int   i;
    med_t lo;
    med_t hi;
    n = eff_window();
    if (rs) begin
      win_sorted.delete();
      win_oldest = 0;
    end
    if (win_sorted.size() >= n) begin
      p = (win_oldest < n) ? win_oldest : 0;
      for (i = 0; i < win_sorted.size(); i++) begin
        if (win_sorted[i] == win_hist[p]) break;
      end
      if (i < win_sorted.size()) win_sorted.delete(i);
      win_hist[p] = s;
      p++;
      win_oldest = (p >= n) ? 0 : p;
    end else begin
      win_hist[win_sorted.size()] = s;
      win_oldest = 0;
    end
    i = win_sorted.size();
    while (i > 0 && win_sorted[i-1] > s) i--;
    win_sorted.insert(i, s);
    if (win_sorted.size() >= n) begin
      lo = win_sorted[(n - 1) / 2];
      hi = win_sorted[n / 2];
      medians_due.insert(medians_due.size(), lo + hi);
    end
  endfunction

  function automatic sample_t pick_sample(input int mode);
    int k;
    if (mode == 0) return sample_t'(int'($urandom_range(0, 16)) - 8);
    if (mode == 1) return sample_t'($urandom());
    k = $urandom_range(0, 4);
    if (k == 0) return S_MIN;
    if (k == 1) return S_MAX;
    if (k == 2) return sample_t'(-1);
    if (k == 3) return '0;
    return sample_t'($urandom());
  endfunction

  task automatic report_mismatch(input string what, input med_t want, input med_t got);
    if (mismatches < PRINT_CAP)
      $display("[%0t] mismatch: %s, expected %0d got %0d", $realtime, what, want, got);
    mismatches++;
  endtask

  // valid is left high after acceptance; wait_drained or a gap in the next call drops it
  task automatic push_sample(input sample_t s, input logic rs);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    restart  <= rs;
    do @(posedge clk); while (in_stall);
    median_step(s, rs);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (medians_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_window_size(input logic [CNT_W-1:0] v);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    win_size_reg = v;
    win_sorted.delete();
    win_oldest = 0;
  endtask

  // receiver: random stall before each result
  always begin : out_drain
    int k;
    @(negedge clk);
    k = out_stalls_on ? $urandom_range(0, MAX_GAP) : 0;
    if (k > 0) begin
      out_stall <= 1'b1;
      repeat (k) @(negedge clk);
    end
    out_stall <= 1'b0;
    do @(posedge clk); while (!out_valid);
  end

  always @(posedge clk) begin : check_results
    med_t want;
    if (!rst && out_valid && !out_stall) begin
      if (medians_due.size() == 0) begin
        report_mismatch("median with no request pending", '0, median_doubled);
      end else begin
        want = medians_due.pop_front();
        if (median_doubled !== want) report_mismatch("median_doubled", want, median_doubled);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // window of 3 from reset
  task automatic test_default_window();
    push_sample(S_MAX, 1'b0);
    push_sample(S_MIN, 1'b0);
    push_sample('0, 1'b0);
    push_sample(sample_t'(-1), 1'b0);
  endtask

  // even window at the sample range limits
  task automatic test_extreme_samples();
    write_window_size(CNT_W'(2));
    push_sample(S_MIN, 1'b0);
    push_sample(S_MIN, 1'b0);
    push_sample(S_MAX, 1'b0);
    push_sample(S_MAX, 1'b0);
  endtask

  // size zero acts as one
  task automatic test_size_limits();
    write_window_size(CNT_W'(0));
    push_sample(sample_t'(5), 1'b0);
    push_sample(sample_t'(-7), 1'b0);
    write_window_size(CNT_W'(1));
    push_sample(S_MAX, 1'b0);
  endtask

  // dropping a duplicate removes only one copy
  task automatic test_duplicates();
    write_window_size(CNT_W'(4));
    push_sample(sample_t'(3), 1'b0);
    push_sample(sample_t'(3), 1'b0);
    push_sample(sample_t'(-3), 1'b0);
    push_sample(sample_t'(3), 1'b0);
    push_sample(sample_t'(3), 1'b0);
  endtask

  // restart and a register write both empty the window
  task automatic test_restart_and_rewrite();
    write_window_size(CNT_W'(3));
    push_sample(sample_t'(1), 1'b0);
    push_sample(sample_t'(2), 1'b0);
    push_sample(sample_t'(3), 1'b0);
    push_sample(sample_t'(10), 1'b1);
    push_sample(sample_t'(20), 1'b0);
    push_sample(sample_t'(30), 1'b0);
    write_window_size(CNT_W'(3));
    push_sample(sample_t'(7), 1'b0);
    push_sample(sample_t'(8), 1'b0);
    push_sample(sample_t'(9), 1'b0);
  endtask

  task automatic test_random_stream();
    int               sent;
    int               seg;
    int               k;
    int               mode;
    int               seg_len;
    logic [CNT_W-1:0] ws;
    sent = 0;
    seg  = 0;
    while (sent < RANDOM_ITEMS) begin
      k = $urandom_range(0, 19);
      if (seg == 0) ws = '1;
      else if (seg == 1) ws = CNT_W'(MAX_WINDOW);
      else if (k == 0) ws = '0;
      else if (k == 1) ws = CNT_W'(MAX_WINDOW);
      else if (k == 2) ws = CNT_W'($urandom_range(MAX_WINDOW + 1, 127));
      else if (k < 5) ws = CNT_W'($urandom_range(17, MAX_WINDOW - 1));
      else ws = CNT_W'($urandom_range(1, 16));
      write_window_size(ws);
      in_gaps_on    = $urandom_range(0, 2) != 0;
      out_stalls_on = $urandom_range(0, 2) != 0;
      mode          = $urandom_range(0, 2);
      seg_len       = eff_window() + $urandom_range(10, 80);
      repeat (seg_len) begin
        if ($urandom_range(0, 99) == 0) wait_drained();
        push_sample(pick_sample(mode), $urandom_range(0, 59) == 0);
        sent++;
      end
      seg++;
    end
  endtask

  initial begin
    win_size_reg = WS_RESET;
    win_oldest   = 0;
    win_hist     = '{default: '0};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_default_window();
    test_extreme_samples();
    test_size_limits();
    test_duplicates();
    test_restart_and_rewrite();
    test_random_stream();
    wait_drained();
    if (mismatches == 0 && medians_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
